/* src/cmr_pkg.sv */
// ----------------------------------------------------------------------------
// cmr_pkg
// Shared constants for the reduced-cost matrix block.
// ----------------------------------------------------------------------------
package cmr_pkg;
    localparam int MAX_NODES = 16;
    localparam int NODE_W    = 4;
    localparam int COST_BITS = 16;
    localparam int ENT_W     = COST_BITS + 1;
    localparam int ADDR_W    = 2 * NODE_W;
    localparam int RED_W     = 21;
    localparam int CNT_W     = NODE_W + 1;

    localparam logic [RED_W-1:0] RED_MAX = {RED_W{1'b1}};

    // opcodes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_MARK   = 2'd1;
    localparam logic [1:0] OP_REDUCE = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    // result kinds
    localparam logic KIND_READ   = 1'b0;
    localparam logic KIND_REDUCE = 1'b1;
endpackage

/* src/cmr_ram.sv */
// ----------------------------------------------------------------------------
// cmr_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cmr_ram #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 17
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [DATA_BITS-1:0] i_wr_data,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [DATA_BITS-1:0] o_rd_data
);
    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

/* src/cost_matrix_reduction.sv */
// ----------------------------------------------------------------------------
// cost_matrix_reduction
// Travel-cost matrix in RAM with load, mark-passed, reduce and read.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake             | Payload
// s       | in  | i_s_tvalid/o_s_tready | tuser: opcode; tdata: row, col, cost, inf
// m       | out | o_m_tvalid/i_m_tready | tuser: result_kind; tdata: results
// cfg     | in  | i_cfg_valid/o_cfg_ready | nodes_in_use
//
// Load writes one entry; mark writes a row, a column and one further entry;
// read scans one row before delivery. In reduce, each line is one RAM scan
// for its minimum and, when the minimum is nonzero, one read-modify-write scan.
// The block has one RAM read port and one write port.
// Input is taken only in the idle state; a finished result waits in the
// output register while loads and marks go on. Reset is synchronous.
// ----------------------------------------------------------------------------
module cost_matrix_reduction
    import cmr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [1:0]  i_s_tuser,    // opcode
    input  logic [31:0] i_s_tdata,    // row_index, col_index, cost_value, is_infinite
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [0:0]  o_m_tuser,    // result_kind
    output logic [55:0] o_m_tdata,    // entry_value, entry_infinite, neighbour_mask,
                                      // reduction_cost
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MROW   = 4'd1;
    localparam logic [3:0] S_MCOL   = 4'd2;
    localparam logic [3:0] S_MLAST  = 4'd3;
    localparam logic [3:0] S_RDSCAN = 4'd4;
    localparam logic [3:0] S_RDWAIT = 4'd5;
    localparam logic [3:0] S_RMIN   = 4'd6;
    localparam logic [3:0] S_RMINW  = 4'd7;
    localparam logic [3:0] S_RDEC   = 4'd8;
    localparam logic [3:0] S_RSUB   = 4'd9;
    localparam logic [3:0] S_RSUBW  = 4'd10;
    localparam logic [3:0] S_RNEXT  = 4'd11;
    localparam logic [3:0] S_FIN    = 4'd12;

    logic [3:0]           r_state, n_state;
    logic [4:0]           r_nodes;
    logic [1:0]           r_op, n_op;
    logic [NODE_W-1:0]    r_row, n_row, r_colv, n_colv;
    logic [NODE_W-1:0]    r_i, n_i;
    logic [NODE_W-1:0]    r_j, n_j;
    logic                 r_colpass, n_colpass;
    logic [COST_BITS-1:0] r_min, n_min;
    logic                 r_found, n_found;
    logic [RED_W-1:0]     r_total, n_total, r_last, n_last;
    logic                 r_dv, n_dv;
    logic [NODE_W-1:0]    r_pa, n_pa;
    logic [ADDR_W-1:0]    r_paddr, n_paddr;
    logic [MAX_NODES-1:0] r_mask, n_mask;
    logic [COST_BITS-1:0] r_ev, n_ev;
    logic                 r_einf, n_einf;
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_kind, n_out_kind;
    logic [55:0]          r_out_data, n_out_data;

    logic                 wr_en, rd_en;
    logic [ADDR_W-1:0]    wr_addr, rd_addr, scan_addr;
    logic [ENT_W-1:0]     wr_data, rd_data;
    logic [CNT_W-1:0]     n_eff;
    logic [NODE_W-1:0]    n_top;
    logic [RED_W:0]       sum;
    logic                 d_inf;
    logic [COST_BITS-1:0] d_val;
    logic                 s_acc;

    cmr_ram #(.ADDR_BITS(ADDR_W), .DATA_BITS(ENT_W)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // clamp node count into 1..MAX_NODES
    always_comb begin
        if (r_nodes == '0) begin
            n_eff = CNT_W'(1);
        end else if (r_nodes > CNT_W'(MAX_NODES)) begin
            n_eff = CNT_W'(MAX_NODES);
        end else begin
            n_eff = r_nodes;
        end
    end
    assign n_top     = NODE_W'(n_eff - CNT_W'(1));
    assign scan_addr = r_colpass ? {r_j, r_i} : {r_i, r_j};
    assign d_inf     = rd_data[ENT_W-1];
    assign d_val     = rd_data[COST_BITS-1:0];
    assign sum       = {1'b0, r_total} + (RED_W+1)'(r_min);

    assign o_s_tready  = (r_state == S_IDLE);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tuser   = r_out_kind;
    assign o_m_tdata   = r_out_data;

    // sequencer and read-modify-write datapath
    always_comb begin
        n_state = r_state;   n_op = r_op;       n_row = r_row;   n_colv = r_colv;
        n_i = r_i;           n_j = r_j;         n_colpass = r_colpass;
        n_min = r_min;       n_found = r_found; n_total = r_total;
        n_last = r_last;     n_dv = 1'b0;       n_pa = r_pa;     n_paddr = r_paddr;
        n_mask = r_mask;     n_ev = r_ev;       n_einf = r_einf;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_kind = r_out_kind; n_out_data = r_out_data;
        wr_en = 1'b0; wr_addr = '0; wr_data = '0;
        rd_en = 1'b0; rd_addr = scan_addr;

        // consume read data of the previous cycle
        if (r_dv) begin
            unique case (r_state)
                S_RMIN, S_RMINW: begin
                    if (!d_inf && (!r_found || d_val < r_min)) begin
                        n_min   = d_val;
                        n_found = 1'b1;
                    end
                end
                S_RSUB, S_RSUBW: begin
                    if (!d_inf) begin
                        wr_en   = 1'b1;
                        wr_addr = r_paddr;
                        wr_data = {1'b0, d_val - r_min};
                    end
                end
                S_RDSCAN, S_RDWAIT: begin
                    if (!d_inf && CNT_W'(r_pa) < n_eff) begin
                        n_mask[r_pa] = 1'b1;
                    end
                    if (r_pa == r_colv) begin
                        n_ev   = d_inf ? '0 : d_val;
                        n_einf = d_inf;
                    end
                end
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_op   = i_s_tuser;
                    n_row  = i_s_tdata[3:0];
                    n_colv = i_s_tdata[7:4];
                    n_j    = '0;
                    unique case (i_s_tuser)
                        OP_LOAD: begin
                            wr_en   = 1'b1;
                            wr_addr = {i_s_tdata[3:0], i_s_tdata[7:4]};
                            wr_data = i_s_tdata[24] ? {1'b1, {COST_BITS{1'b0}}}
                                                    : {1'b0, i_s_tdata[23:8]};
                        end
                        OP_MARK:   n_state = S_MROW;
                        OP_REDUCE: begin
                            n_i       = '0;
                            n_colpass = 1'b0;
                            n_found   = 1'b0;
                            n_total   = '0;
                            n_state   = S_RMIN;
                        end
                        OP_READ: begin
                            n_mask  = '0;
                            n_state = S_RDSCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_MROW: begin
                wr_en   = 1'b1;
                wr_addr = {r_row, r_j};
                wr_data = {1'b1, {COST_BITS{1'b0}}};
                n_j     = r_j + NODE_W'(1);
                if (r_j == n_top) begin
                    n_j     = '0;
                    n_state = S_MCOL;
                end
            end
            S_MCOL: begin
                wr_en   = 1'b1;
                wr_addr = {r_j, r_colv};
                wr_data = {1'b1, {COST_BITS{1'b0}}};
                n_j     = r_j + NODE_W'(1);
                if (r_j == n_top) begin
                    n_state = S_MLAST;
                end
            end
            S_MLAST: begin
                wr_en   = 1'b1;
                wr_addr = {r_colv, {NODE_W{1'b0}}};
                wr_data = {1'b1, {COST_BITS{1'b0}}};
                n_state = S_IDLE;
            end
            S_RDSCAN: begin
                rd_en   = 1'b1;
                rd_addr = {r_row, r_j};
                n_dv    = 1'b1;
                n_pa    = r_j;
                n_j     = r_j + NODE_W'(1);
                if (r_j == NODE_W'(MAX_NODES - 1)) begin
                    n_state = S_RDWAIT;
                end
            end
            S_RDWAIT: n_state = S_FIN;
            S_RMIN, S_RSUB: begin
                rd_en   = 1'b1;
                n_dv    = 1'b1;
                n_paddr = scan_addr;
                n_j     = r_j + NODE_W'(1);
                if (r_j == n_top) begin
                    n_state = (r_state == S_RMIN) ? S_RMINW : S_RSUBW;
                end
            end
            S_RMINW: n_state = S_RDEC;
            S_RDEC: begin
                n_j = '0;
                if (r_found && r_min != '0) begin
                    n_total = sum[RED_W] ? RED_MAX : sum[RED_W-1:0];
                    n_state = S_RSUB;
                end else begin
                    n_state = S_RNEXT;
                end
            end
            S_RSUBW: n_state = S_RNEXT;
            S_RNEXT: begin
                n_j     = '0;
                n_found = 1'b0;
                n_state = S_RMIN;
                n_i     = r_i + NODE_W'(1);
                if (r_i == n_top) begin
                    n_i = '0;
                    if (r_colpass) begin
                        n_state = S_FIN;
                    end else begin
                        n_colpass = 1'b1;
                    end
                end
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_op == OP_REDUCE) begin
                        n_last     = r_total;
                        n_out_kind = KIND_REDUCE;
                        n_out_data = {2'b0, r_total, {MAX_NODES{1'b0}}, 1'b0,
                                      {COST_BITS{1'b0}}};
                    end else begin
                        n_out_kind = KIND_READ;
                        n_out_data = {2'b0, r_last, r_mask, r_einf, r_ev};
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nodes     <= 5'd16;
            r_last      <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_dv        <= n_dv;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_nodes <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op <= n_op;       r_row <= n_row;     r_colv <= n_colv;
        r_i <= n_i;         r_j <= n_j;         r_colpass <= n_colpass;
        r_min <= n_min;     r_found <= n_found; r_total <= n_total;
        r_pa <= n_pa;       r_paddr <= n_paddr; r_mask <= n_mask;
        r_ev <= n_ev;       r_einf <= n_einf;
        r_out_kind <= n_out_kind;
        r_out_data <= n_out_data;
    end

`ifndef NO_ASSERTIONS
    a_no_rw_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write hit the same entry");
    a_dv_follows_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> $past(rd_en))
        else $error("read data flagged without a read");
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("result raised outside finish state");
`endif
endmodule
